// File: hdl/gzoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro zero offset calibrator package
// Shared widths, phase codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gzoc_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Field widths
    localparam int RATE_W  = 16;   // raw gyro sample field
    localparam int COUNT_W = 16;   // sample_count and samples_left
    localparam int SUM_W   = 33;   // saturating axis sum
    localparam int OFS_W   = 24;   // zero offset output
    localparam int PHASE_W = 2;
    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 80;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = '0;
    localparam logic [COUNT_W-1:0]   SAMPLE_COUNT_RST = 16'd1024;

    // Calibration phases
    localparam logic [PHASE_W-1:0] PH_READY   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_COLLECT = 2'd2;

    // Axis selects
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;       // capture the input request
        logic              clear;      // clear sums and offsets, load count
        logic              accum;      // add sample to sums, step count
        logic              div_start;  // start the mean division for axis
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    // Datapath and output side status to the controller
    typedef struct packed {
        logic start;        // captured start_request
        logic still;        // captured device_still
        logic left_is_one;  // samples_left is one before the step
        logic div_zero;     // divisor of the running mean is zero
        logic div_done;     // quotient ready
        logic out_free;     // output register can take a result
    } sts_t;

    // Result control to the output register
    typedef struct packed {
        logic               load;
        logic               updated;
        logic               run_done;
        logic [PHASE_W-1:0] phase;
    } emit_t;

endpackage

// File: hdl/gzoc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle; the numerator register
// shifts out dividend bits and shifts in quotient bits.
// ----------------------------------------------------------------------------
module gzoc_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg[DEN_W-1:0], nq_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            nq_reg  <= {nq_reg[NUM_W-2:0], fits};
        end
    end

    assign quo  = nq_reg;
    assign done = done_reg;

endmodule

// File: hdl/gzoc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro zero offset calibrator datapath
// Captured request, saturating axis sums, remaining-sample count, held offsets
// and the shared serial divider that forms the rounded running means.
// ----------------------------------------------------------------------------
module gzoc_dp #(
    parameter int SAMPLE_BITS   = gzoc_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = gzoc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  gzoc_pkg::cmd_t                                cmd,
    input  logic [gzoc_pkg::S_TDATA_W-1:0]                in_data,
    input  logic [gzoc_pkg::COUNT_W-1:0]                  sample_count,
    output logic                                          start,
    output logic                                          still,
    output logic                                          left_is_one,
    output logic                                          div_zero,
    output logic                                          div_done,
    output logic [gzoc_pkg::AXES-1:0][gzoc_pkg::OFS_W-1:0] offsets
);

    import gzoc_pkg::*;

    localparam int NUM_W = SUM_W + FRACTION_BITS;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [OFS_W-1:0]        OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic [OFS_W-1:0]        OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};
    localparam logic [NUM_W-1:0]        Q_POS_LIM = NUM_W'(OFS_MAX);
    localparam logic [NUM_W-1:0]        Q_NEG_LIM = NUM_W'(OFS_MIN);

    logic                     start_reg;
    logic                     still_reg;
    logic [RATE_W-1:0]        rate_reg [AXES];
    logic signed [SUM_W-1:0]  sum_reg  [AXES];
    logic [COUNT_W-1:0]       left_reg;
    logic [OFS_W-1:0]         ofs_reg  [AXES];

    logic signed [SUM_W-1:0]  sample   [AXES];
    logic signed [SUM_W-1:0]  sum_next [AXES];
    logic signed [SUM_W:0]    sum_wide [AXES];
    logic [COUNT_W-1:0]       den;
    logic signed [SUM_W-1:0]  sum_sel;
    logic [SUM_W-1:0]         mag;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         quo;
    logic                     quo_done;
    logic [OFS_W-1:0]         ofs_sat;

    // Sign-extend the low SAMPLE_BITS of each raw field; above RATE_W, zero-extend the field
    generate
        if (SAMPLE_BITS <= RATE_W)
        begin : g_sext
            always_comb
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    sample[i] = SUM_W'($signed(rate_reg[i][SAMPLE_BITS-1:0]));
                end
            end
        end
        else
        begin : g_zext
            always_comb
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    sample[i] = $signed(SUM_W'(rate_reg[i]));
                end
            end
        end
    endgenerate

    // Saturating sum update
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            sum_wide[i] = {sum_reg[i][SUM_W-1], sum_reg[i]}
                        + {sample[i][SUM_W-1], sample[i]};
            if (sum_wide[i][SUM_W] != sum_wide[i][SUM_W-1])
            begin
                sum_next[i] = sum_wide[i][SUM_W] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                sum_next[i] = sum_wide[i][SUM_W-1:0];
            end
        end
    end

    // Divisor is the number of samples taken so far
    assign den = sample_count - left_reg;

    // Numerator: magnitude with fraction bits, plus half the divisor to round
    always_comb
    begin
        sum_sel = sum_reg[cmd.axis];
        mag     = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
        num     = (NUM_W'(mag) << FRACTION_BITS) + NUM_W'(den >> 1);
    end

    gzoc_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_W)
    ) i_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den),
        .quo   (quo),
        .done  (quo_done)
    );

    // Saturate the quotient and restore the sign
    always_comb
    begin
        if (sum_sel[SUM_W-1])
        begin
            ofs_sat = (quo > Q_NEG_LIM) ? OFS_MIN : (OFS_W'(0) - quo[OFS_W-1:0]);
        end
        else
        begin
            ofs_sat = (quo > Q_POS_LIM) ? OFS_MAX : quo[OFS_W-1:0];
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg   <= in_data[0];
            still_reg   <= in_data[1];
            rate_reg[0] <= in_data[2 +: RATE_W];
            rate_reg[1] <= in_data[2 + RATE_W +: RATE_W];
            rate_reg[2] <= in_data[2 + 2*RATE_W +: RATE_W];
        end
    end

    // Calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
                ofs_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                left_reg <= sample_count;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_reg[i] <= '0;
                    ofs_reg[i] <= '0;
                end
            end
            else if (cmd.accum)
            begin
                left_reg <= left_reg - 1'b1;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
            end
            else if (quo_done)
            begin
                ofs_reg[cmd.axis] <= ofs_sat;
            end
        end
    end

    assign start       = start_reg;
    assign still       = still_reg;
    assign left_is_one = (left_reg == COUNT_W'(1));
    assign div_zero    = (den == '0);
    assign div_done    = quo_done;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            offsets[i] = ofs_reg[i];
        end
    end

endmodule

// File: hdl/gzoc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro zero offset calibrator controller
// Calibration phase register and the sequencer that steps one request through
// capture, sum update, the three mean divisions when collecting, and result hand-off.
// ----------------------------------------------------------------------------
module gzoc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gzoc_pkg::sts_t  sts,
    output gzoc_pkg::cmd_t  cmd,
    output gzoc_pkg::emit_t emit
);

    import gzoc_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_STEP      = 3'd1;
    localparam logic [2:0] ST_DIV_START = 3'd2;
    localparam logic [2:0] ST_DIV_RUN   = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [2:0]         state_reg,   state_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic               updated_reg, updated_next;
    logic               done_reg,    done_next;
    logic [AXIS_W-1:0]  axis_reg,    axis_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        updated_next  = updated_reg;
        done_next     = done_reg;
        axis_next     = axis_reg;
        cmd           = '0;
        cmd.axis      = axis_reg;
        emit          = '0;
        emit.updated  = updated_reg;
        emit.run_done = done_reg;
        emit.phase    = phase_reg;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                updated_next = 1'b1;
                done_next    = 1'b0;
                axis_next    = AXIS_X;
                state_next   = ST_EMIT;
                case (phase_reg)
                    PH_WAIT:
                    begin
                        cmd.clear  = 1'b1;
                        phase_next = PH_COLLECT;
                    end
                    PH_COLLECT:
                    begin
                        if (sts.still)
                        begin
                            cmd.accum  = 1'b1;
                            done_next  = sts.left_is_one;
                            phase_next = sts.left_is_one ? PH_READY : PH_COLLECT;
                            state_next = ST_DIV_START;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                    default:
                    begin
                        phase_next   = sts.start ? PH_WAIT : PH_READY;
                        updated_next = sts.start;
                    end
                endcase
            end

            ST_DIV_START:
            begin
                if (sts.div_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_RUN;
                end
            end

            ST_DIV_RUN:
            begin
                if (sts.div_done)
                begin
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end

            ST_EMIT:
            begin
                emit.load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_READY;
            updated_reg <= 1'b0;
            done_reg    <= 1'b0;
            axis_reg    <= AXIS_X;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            updated_reg <= updated_next;
            done_reg    <= done_next;
            axis_reg    <= axis_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // A request is taken only once per pass through the sequencer
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a previous one is in work");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> sts.out_free)
        else $error("result loaded into a full output register");

    // No division by a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_zero)
        else $error("division started with zero divisor");

    // Quotients arrive only while the sequencer waits for them
    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_DIV_RUN))
        else $error("unexpected quotient");

endmodule

// File: hdl/gyro_zero_offset_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro zero offset calibrator
// Averages still three-axis gyro samples into per-axis zero offsets.
//
//   Channel   Direction  Handshake               Contents
//   s_axis    in         tvalid / tready         one gyro sample request
//   m_axis    out        tvalid / tready         one result per request
//   apb       in         psel/penable/pready     sample_count at offset 0x0
//
// A collecting request with the device still runs the three mean divisions in
// turn: one serial divider is shared by the three axes and yields one quotient
// bit per cycle. A still request whose divisor is zero skips the divisions;
// every other request goes from capture straight to the result.
// Reset is asynchronous and active low; it returns the phase to ready, clears
// the held offsets and loads sample_count with 1024.
// A result waits in the output register while the next request is accepted;
// the sequencer stalls only when a new result finds that register still full.
// ----------------------------------------------------------------------------
module gyro_zero_offset_calibrator #(
    parameter int SAMPLE_BITS   = gzoc_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = gzoc_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // [0] start_request, [1] device_still, [17:2] x_rate, [33:18] y_rate,
    // [49:34] z_rate, [55:50] zero
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gzoc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] updated, [2:1] phase_now, [3] run_done, [27:4] x_bias,
    // [51:28] y_bias, [75:52] z_bias, [79:76] zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gzoc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gzoc_pkg::PADDR_W-1:0]   paddr,
    input  logic [gzoc_pkg::PDATA_W-1:0]   pwdata,
    output logic [gzoc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    import gzoc_pkg::*;

    localparam int RES_W = 4 + AXES * OFS_W;

    logic [COUNT_W-1:0]            count_reg;
    logic                          out_valid_reg;
    logic [M_TDATA_W-1:0]          out_data_reg;
    logic [REG_IDX_W-1:0]          reg_idx;

    cmd_t                          cmd;
    sts_t                          sts;
    emit_t                         emit;
    logic [AXES-1:0][OFS_W-1:0]    offsets;
    logic                          dp_start;
    logic                          dp_still;
    logic                          dp_left_is_one;
    logic                          dp_div_zero;
    logic                          dp_div_done;

    // Configuration register
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_SAMPLE_COUNT) ? PDATA_W'(count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= SAMPLE_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_SAMPLE_COUNT))
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    gzoc_ctrl i_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .emit     (emit)
    );

    gzoc_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_data      (s_axis_tdata),
        .sample_count (count_reg),
        .start        (dp_start),
        .still        (dp_still),
        .left_is_one  (dp_left_is_one),
        .div_zero     (dp_div_zero),
        .div_done     (dp_div_done),
        .offsets      (offsets)
    );

    // Gather status for the controller
    assign sts = '{start:       dp_start,
                   still:       dp_still,
                   left_is_one: dp_left_is_one,
                   div_zero:    dp_div_zero,
                   div_done:    dp_div_done,
                   out_free:    (!out_valid_reg || m_axis_tready)};

    // Output register: hold a result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_data_reg <= M_TDATA_W'({offsets[2], offsets[1], offsets[0],
                                        emit.run_done, emit.phase, emit.updated});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg[M_TDATA_W-1:RES_W] & '0,
                            out_data_reg[RES_W-1:0]};

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro zero offset calibrator testbench
// Drives gyro sample requests into the stream input and programs sample_count
// over APB while the block is idle. A scoreboard class predicts every result
// from its own copy of the calibration state and checks the output stream
// field by field. Random requests follow the predicted phase so that most runs
// reach collection and completion, with motion and stray start requests mixed
// in. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import gzoc_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 140;

    localparam longint SUM_HI = 64'sd4294967295;
    localparam longint SUM_LO = -64'sd4294967296;
    localparam longint OFS_HI = 64'sd8388607;
    localparam longint OFS_LO = -64'sd8388608;

    // Scoreboard: calibration predictor and queue of results due
    class calib_scoreboard;
        typedef struct packed {
            logic               updated;
            logic [PHASE_W-1:0] phase;
            logic               run_done;
            logic [OFS_W-1:0]   x_ofs;
            logic [OFS_W-1:0]   y_ofs;
            logic [OFS_W-1:0]   z_ofs;
        } offset_result_t;

        offset_result_t     results_due[$];
        logic [PHASE_W-1:0] phase;
        longint             sums[AXES];
        longint             offsets[AXES];
        logic [COUNT_W-1:0] left;
        logic [COUNT_W-1:0] count;
        int                 errors;

        function new();
            phase  = PH_READY;
            left   = '0;
            count  = SAMPLE_COUNT_RST;
            errors = 0;
            foreach (sums[i])
            begin
                sums[i]    = 0;
                offsets[i] = 0;
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function void set_count(input logic [PDATA_W-1:0] v);
            count = v[COUNT_W-1:0];
        endfunction

        // Round the mean to nearest, ties away from zero, then saturate
        function longint fixed_mean(input longint sum, input longint unsigned dv);
            bit                neg;
            longint unsigned   mag;
            longint unsigned   q;
            neg = sum < 0;
            mag = neg ? longint'(-sum) : longint'(sum);
            q   = ((mag << FRACTION_BITS_DEF) + dv / 2) / dv;
            if (neg)
                return (q > longint'(-OFS_LO)) ? OFS_LO : -longint'(q);
            return (q > longint'(OFS_HI)) ? OFS_HI : longint'(q);
        endfunction

        // Advance the predicted state by one accepted request
        function void note_request(input logic [S_TDATA_W-1:0] d);
            logic signed [RATE_W-1:0] rate[AXES];
            logic [COUNT_W-1:0]       dv;
            longint                   s;
            offset_result_t           r;
            r.updated  = 1'b1;
            r.run_done = 1'b0;
            rate[0] = d[17:2];
            rate[1] = d[33:18];
            rate[2] = d[49:34];
            case (phase)
                PH_WAIT:
                begin
                    foreach (sums[i])
                    begin
                        sums[i]    = 0;
                        offsets[i] = 0;
                    end
                    left  = count;
                    phase = PH_COLLECT;
                end
                PH_COLLECT:
                begin
                    if (d[1])
                    begin
                        foreach (sums[i])
                        begin
                            s = sums[i] + longint'(rate[i]);
                            if (s > SUM_HI)
                                s = SUM_HI;
                            if (s < SUM_LO)
                                s = SUM_LO;
                            sums[i] = s;
                        end
                        left = left - 1'b1;
                        dv   = count - left;
                        // hold the offsets when the divisor wraps to zero
                        if (dv != '0)
                            foreach (offsets[i])
                                offsets[i] = fixed_mean(sums[i], longint'(dv));
                        if (left == '0)
                        begin
                            r.run_done = 1'b1;
                            phase      = PH_READY;
                        end
                    end
                    else
                        phase = PH_WAIT;
                end
                default:
                begin
                    if (d[0])
                        phase = PH_WAIT;
                    else
                    begin
                        phase     = PH_READY;
                        r.updated = 1'b0;
                    end
                end
            endcase
            r.phase = phase;
            r.x_ofs = OFS_W'(offsets[0]);
            r.y_ofs = OFS_W'(offsets[1]);
            r.z_ofs = OFS_W'(offsets[2]);
            results_due.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        task check_result(input logic [M_TDATA_W-1:0] t);
            offset_result_t e;
            if (results_due.size() == 0)
            begin
                report("result with no request pending");
                return;
            end
            e = results_due.pop_front();
            if (t[0] !== e.updated)
                report($sformatf("updated got %b exp %b", t[0], e.updated));
            if (t[2:1] !== e.phase)
                report($sformatf("phase_now got %0d exp %0d", t[2:1], e.phase));
            if (t[3] !== e.run_done)
                report($sformatf("run_done got %b exp %b", t[3], e.run_done));
            if (t[27:4] !== e.x_ofs)
                report($sformatf("x_bias got %h exp %h", t[27:4], e.x_ofs));
            if (t[51:28] !== e.y_ofs)
                report($sformatf("y_bias got %h exp %h", t[51:28], e.y_ofs));
            if (t[75:52] !== e.z_ofs)
                report($sformatf("z_bias got %h exp %h", t[75:52], e.z_ofs));
            if (t[79:76] !== 4'b0)
                report($sformatf("padding got %h", t[79:76]));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [0] start_request, [1] device_still, [17:2] x_rate, [33:18] y_rate,
    // [49:34] z_rate, [55:50] zero
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [0] updated, [2:1] phase_now, [3] run_done, [27:4] x_bias,
    // [51:28] y_bias, [75:52] z_bias, [79:76] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    calib_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              sink_hold = 0;
    int              cycles = 0;

    gyro_zero_offset_calibrator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int k;
        if (quiet)
            return 0;
        k = $urandom_range(0, 19);
        if (k == 0)
            return $urandom_range(20, 150);
        if (k < 8)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return RATE_W'(int'($urandom_range(0, 200)) - 100);
            default: return RATE_W'($urandom);
        endcase
    endfunction

    // Result side: stall at random
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_hold = pick_gap();
            end
        end
    end

    // Check every accepted result
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // Present one request, hold it until accepted, then idle for a random gap
    task automatic send_request(input logic start, input logic still,
                                input logic [RATE_W-1:0] xr, input logic [RATE_W-1:0] yr,
                                input logic [RATE_W-1:0] zr);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, zr, yr, xr, still, start};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(s_axis_tdata);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic collect(input logic [RATE_W-1:0] xr, input logic [RATE_W-1:0] yr,
                           input logic [RATE_W-1:0] zr);
        send_request(1'b0, 1'b1, xr, yr, zr);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write sample_count while idle, then read it back
    task automatic program_count(input logic [PDATA_W-1:0] v);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SAMPLE_COUNT, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_count(v);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {16'b0, v[COUNT_W-1:0]})
            sb.report($sformatf("sample_count read %h exp %h", prdata, v[COUNT_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        int unsigned count_plan[9];
        int          target;
        int          sent;
        logic        start;
        logic        still;
        logic        ignored;

        count_plan = '{1, 3, 65535, 2, 7, 1, 12, 40, 5};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle request, then a run at the reset count with extreme samples
        send_request(1'b0, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_request(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        collect(16'h7FFF, 16'h8000, 16'h0000);
        collect(16'h8000, 16'h7FFF, 16'hFFFF);
        collect(16'h0001, 16'hFFFF, 16'h0001);
        // motion drops back to waiting; restart collection
        send_request(1'b1, 1'b0, 16'h1234, 16'h5678, 16'h9ABC);
        send_request(1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        collect(16'h7FFF, 16'h8000, 16'h1234);
        // count changed mid-run: wrapped divisor, then zero divisor, then one
        program_count(32'd2);
        collect(16'h7FFF, 16'h8000, 16'hEDCC);
        program_count(32'd1021);
        collect(16'h7FFF, 16'h8000, 16'h0F0F);
        collect(16'h7FFF, 16'h8000, 16'hF0F0);
        // single-sample run with junk in the upper register bits
        send_request(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        program_count(32'hFFFF_0001);
        send_request(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        collect(16'h8000, 16'h7FFF, 16'h0005);
        send_request(1'b0, 1'b1, 16'h7FFF, 16'h8000, 16'h0001);
        // zero count wraps to a full-length run
        program_count(32'hA5A5_0000);
        send_request(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        collect(16'h0100, 16'hFF00, 16'h7FFF);
        collect(16'h0003, 16'hFFFD, 16'h8000);
        send_request(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_request(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        collect(16'h4000, 16'hC000, 16'h0000);
        program_count(32'd65535);
        collect(16'h4000, 16'hC000, 16'h0001);

        // Random phases, each at its own sample_count
        target = RANDOM_ITEMS / ($size(count_plan) + 1);
        for (int p = 0; p <= $size(count_plan); p++)
        begin
            quiet = (p % 3 == 2);
            if (p < $size(count_plan))
                program_count(count_plan[p] | (p[0] ? ($urandom << 16) : 0));
            else
                program_count($urandom_range(1, 20));
            sent = 0;
            while (sent < target)
            begin
                start = $urandom_range(0, 1);
                still = $urandom_range(0, 1);
                if (sb.phase == PH_COLLECT)
                    still = ($urandom_range(0, 24) != 0);
                else if (sb.phase != PH_WAIT)
                    start = ($urandom_range(0, 5) != 0);
                ignored = (sb.phase != PH_WAIT) && (sb.phase != PH_COLLECT) && !start;
                send_request(start, still, pick_rate(), pick_rate(), pick_rate());
                if (!ignored)
                    sent++;
            end
        end

        // Drain and report
        quiet = 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
